// ===== hw/rtl/bds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box downsampler package
// Shared widths, register indexes and the operation types passed from the
// pixel front end to the line-buffer back end.
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int CFG_W     = 11;  // configuration data width
    localparam int CFG_IDX_W = 1;   // configuration register index width
    localparam int SIZE_W    = 14;  // holds any frame size up to 8192
    localparam int CH_W      = 8;   // one color channel
    localparam int SUM_W     = 9;   // sum of two channels

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'd1;

    typedef struct packed {
        logic [SUM_W-1:0] sum_blue;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_red;
    } pair_sum_t;

    typedef struct packed {
        logic is_read;   // odd row: combine with the stored sum and emit
        logic last;      // final block of the reduced frame
    } op_ctl_t;

endpackage

// ===== hw/rtl/bds_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module bds_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bds_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operation queue
// Small register FIFO between the pixel front end and the back end.
// ----------------------------------------------------------------------------
module bds_fifo #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/bds_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Downsampler front end
// Tracks the raster position, pairs even and odd columns and issues one
// store or combine operation per pixel pair.
// ----------------------------------------------------------------------------
module bds_front
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int IDX_W      = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 accept,
    input  logic [CH_W-1:0]      pixel_red,
    input  logic [CH_W-1:0]      pixel_green,
    input  logic [CH_W-1:0]      pixel_blue,
    output logic                 op_push,
    output op_ctl_t              op_ctl,
    output logic [IDX_W-1:0]     op_idx,
    output pair_sum_t            op_sums
);

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    localparam logic [COL_W-1:0] RST_W_M1      = COL_W'(RST_W - 1);
    localparam logic [COL_W-1:0] RST_USED_W_M1 = COL_W'((RST_W / 2) * 2 - 1);
    localparam logic [ROW_W-1:0] RST_H_M1      = ROW_W'(RST_H - 1);
    localparam logic [ROW_W-1:0] RST_USED_H_M1 = ROW_W'((RST_H / 2) * 2 - 1);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                     input logic [SIZE_W-1:0] top);
        logic [SIZE_W-1:0] ext;
        ext = SIZE_W'(v);
        if (ext < SIZE_W'(2))
        begin
            return SIZE_W'(2);
        end
        else if (ext > top)
        begin
            return top;
        end
        return ext;
    endfunction

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] w_m1_reg, w_m1_next;
    logic [COL_W-1:0] used_w_m1_reg, used_w_m1_next;
    logic [ROW_W-1:0] h_m1_reg, h_m1_next;
    logic [ROW_W-1:0] used_h_m1_reg, used_h_m1_next;
    logic [3*CH_W-1:0] held_reg, held_next;

    logic [SIZE_W-1:0] w_clamped;
    logic [SIZE_W-1:0] h_clamped;
    logic              last_col;
    logic              last_row;

    assign w_clamped = clamp_size(cfg_data, SIZE_W'(MAX_WIDTH));
    assign h_clamped = clamp_size(cfg_data, SIZE_W'(MAX_HEIGHT));
    assign last_col  = (col_reg == w_m1_reg);
    assign last_row  = (row_reg == h_m1_reg);

    // Odd column inside the even-sized part of the frame; drop a trailing odd row.
    assign op_push = accept && col_reg[0] && !(last_row && !row_reg[0]);

    assign op_ctl.is_read = row_reg[0];
    assign op_ctl.last    = (col_reg == used_w_m1_reg) && (row_reg == used_h_m1_reg);
    assign op_idx         = IDX_W'(col_reg >> 1);

    assign op_sums.sum_red   = SUM_W'(held_reg[CH_W-1:0])        + SUM_W'(pixel_red);
    assign op_sums.sum_green = SUM_W'(held_reg[2*CH_W-1:CH_W])   + SUM_W'(pixel_green);
    assign op_sums.sum_blue  = SUM_W'(held_reg[3*CH_W-1:2*CH_W]) + SUM_W'(pixel_blue);

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        w_m1_next      = w_m1_reg;
        used_w_m1_next = used_w_m1_reg;
        h_m1_next      = h_m1_reg;
        used_h_m1_next = used_h_m1_reg;
        held_next      = held_reg;

        if (accept)
        begin
            if (!col_reg[0])
            begin
                held_next = {pixel_blue, pixel_green, pixel_red};
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        // A register write restarts the frame.
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:
                begin
                    w_m1_next      = COL_W'(w_clamped - SIZE_W'(1));
                    used_w_m1_next = COL_W'({w_clamped[SIZE_W-1:1], 1'b0} - SIZE_W'(1));
                end
                REG_SOURCE_HEIGHT:
                begin
                    h_m1_next      = ROW_W'(h_clamped - SIZE_W'(1));
                    used_h_m1_next = ROW_W'({h_clamped[SIZE_W-1:1], 1'b0} - SIZE_W'(1));
                end
                default:
                begin
                end
            endcase
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            w_m1_reg      <= RST_W_M1;
            used_w_m1_reg <= RST_USED_W_M1;
            h_m1_reg      <= RST_H_M1;
            used_h_m1_reg <= RST_USED_H_M1;
            held_reg      <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            w_m1_reg      <= w_m1_next;
            used_w_m1_reg <= used_w_m1_next;
            h_m1_reg      <= h_m1_next;
            used_h_m1_reg <= used_h_m1_next;
            held_reg      <= held_next;
        end
    end

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (col_reg == '0) && (row_reg == '0))
        else $error("configuration write did not restart the frame");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= w_m1_reg) && (row_reg <= h_m1_reg))
        else $error("raster position beyond frame size");

    a_last_is_read: assert property (@(posedge clk) disable iff (!rst_n)
        (op_push && op_ctl.last) |-> op_ctl.is_read)
        else $error("last mark on a store operation");

endmodule

// ===== hw/rtl/bds_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Downsampler back end
// Stores even-row pair sums in the half-line buffer, and on odd rows reads
// the sum from the row above, averages the block and registers the result.
// ----------------------------------------------------------------------------
module bds_back
    import bds_pkg::*;
#(
    parameter int LINE_DEPTH = 512,
    parameter int IDX_W      = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    input  op_ctl_t          op_ctl,
    input  logic [IDX_W-1:0] op_idx,
    input  pair_sum_t        op_sums,
    output logic             op_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CH_W-1:0]  out_red,
    output logic [CH_W-1:0]  out_green,
    output logic [CH_W-1:0]  out_blue,
    output logic             frame_last
);

    localparam int PS_W = $bits(pair_sum_t);

    logic      s1_valid_reg, s1_valid_next;
    pair_sum_t s1_sum_reg;
    logic      s1_last_reg;

    logic            out_valid_reg, out_valid_next;
    logic [CH_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic            out_last_reg;

    logic      out_free;
    logic      s1_free;
    logic      ram_we;
    logic      ram_re;
    pair_sum_t above;

    logic [SUM_W:0] tot_red, tot_green, tot_blue;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign op_pop   = op_valid && (!op_ctl.is_read || s1_free);
    assign ram_we   = op_pop && !op_ctl.is_read;
    assign ram_re   = op_pop && op_ctl.is_read;

    bds_ram #(
        .WIDTH (PS_W),
        .DEPTH (LINE_DEPTH),
        .AW    (IDX_W)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_idx),
        .wdata (op_sums),
        .re    (ram_re),
        .raddr (op_idx),
        .rdata (above)
    );

    assign tot_red   = (SUM_W + 1)'(s1_sum_reg.sum_red)   + (SUM_W + 1)'(above.sum_red);
    assign tot_green = (SUM_W + 1)'(s1_sum_reg.sum_green) + (SUM_W + 1)'(above.sum_green);
    assign tot_blue  = (SUM_W + 1)'(s1_sum_reg.sum_blue)  + (SUM_W + 1)'(above.sum_blue);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_free)
        begin
            s1_valid_next = ram_re;
        end
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_sum_reg  <= op_sums;
            s1_last_reg <= op_ctl.last;
        end
        if (out_free && s1_valid_reg)
        begin
            out_red_reg   <= tot_red[SUM_W:2];
            out_green_reg <= tot_green[SUM_W:2];
            out_blue_reg  <= tot_blue[SUM_W:2];
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign frame_last = out_last_reg;

    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line buffer read and write in one cycle");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg && $stable(s1_sum_reg)
                                        && $stable(above))
        else $error("combine stage lost its operands under stall");

    a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("combine result not moved to output register");

endmodule

// ===== hw/rtl/box_downsample_by_two.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 2x2 box-filter downsampler
// Averages each 2x2 block of an RGB raster stream into one output pixel.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------
//  pixel in | in_valid / in_ready  | pixel_red, pixel_green, pixel_blue
//  block out| out_valid / out_ready| out_red, out_green, out_blue, frame_last
//  config   | cfg_we               | cfg_index, cfg_data
//
//  One pixel per clock while in_ready is high; a result leaves through the
//  queue, the line-buffer read and the output register after the odd-row,
//  odd-column pixel that completes its block. in_ready drops only when the
//  four-entry operation queue is full, which happens only while out_ready
//  is held low. Reset clears the raster position and loads sizes of MAX_WIDTH
//  by MAX_HEIGHT, each capped at 1024; the line buffer needs no clearing.
// ----------------------------------------------------------------------------
module box_downsample_by_two
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CH_W-1:0]      pixel_red,
    input  logic [CH_W-1:0]      pixel_green,
    input  logic [CH_W-1:0]      pixel_blue,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CH_W-1:0]      out_red,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_blue,
    output logic                 frame_last
);

    localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CTL_W      = $bits(op_ctl_t);
    localparam int PS_W       = $bits(pair_sum_t);
    localparam int Q_W        = IDX_W + CTL_W + PS_W;
    localparam int Q_DEPTH    = 4;

    logic             accept;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             f_push;
    op_ctl_t          f_ctl;
    logic [IDX_W-1:0] f_idx;
    pair_sum_t        f_sums;
    logic [Q_W-1:0]   q_out;
    op_ctl_t          b_ctl;
    logic [IDX_W-1:0] b_idx;
    pair_sum_t        b_sums;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    bds_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .IDX_W      (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .op_push     (f_push),
        .op_ctl      (f_ctl),
        .op_idx      (f_idx),
        .op_sums     (f_sums)
    );

    bds_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data ({f_idx, f_ctl, f_sums}),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {b_idx, b_ctl, b_sums} = q_out;

    bds_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (!q_empty),
        .op_ctl     (b_ctl),
        .op_idx     (b_idx),
        .op_sums    (b_sums),
        .op_pop     (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .frame_last (frame_last)
    );

endmodule
